/* rtl/core/tkwr_pkg.sv */
// ----------------------------------------------------------------------------
// tkwr_pkg: shared types and constants for the top-k and window range tracker
// Holds beat structs, result kind codes and default parameter values.
// ----------------------------------------------------------------------------
`default_nettype none
package tkwr_pkg;
  localparam int TOP_COUNT_DEF      = 5;
  localparam int WINDOW_MINUTES_DEF = 10;
  localparam int REPORT_MINUTES_DEF = 60;

  localparam logic [1:0] KIND_HIGH = 2'd0;
  localparam logic [1:0] KIND_LOW  = 2'd1;
  localparam logic [1:0] KIND_DIFF = 2'd2;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [5:0]         minute;
    logic               last_of_report;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         rank;
    logic [5:0]         at_minute;
    logic signed [15:0] sample_value;
    logic [15:0]        difference;
    logic               entry_valid;
    logic               last_result;
  } out_beat_t;
endpackage
`default_nettype wire

/* rtl/core/tkwr_front.sv */
// ----------------------------------------------------------------------------
// tkwr_front: input stage
// Clamps the minute of each beat and hands it to a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module tkwr_front #(
  parameter int REPORT_MINUTES = 60
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tkwr_pkg::in_beat_t in_data,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output tkwr_pkg::in_beat_t      q_data
);
  import tkwr_pkg::*;
  localparam logic [5:0] MAX_MIN = 6'((REPORT_MINUTES > 64 ? 64 : REPORT_MINUTES) - 1);

  in_beat_t  mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  in_beat_t  cl;
  logic      push, pop;

  always_comb begin
    cl = in_data;
    if (REPORT_MINUTES < 64 && in_data.minute > MAX_MIN) cl.minute = MAX_MIN;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cl;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/core/tkwr_back.sv */
// ----------------------------------------------------------------------------
// tkwr_back: list, window and report engine
// Inserts samples into sorted lists, steps minutes, scores windows, reports.
// ----------------------------------------------------------------------------
`default_nettype none
module tkwr_back #(
  parameter int TOP_COUNT      = 5,
  parameter int WINDOW_MINUTES = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire tkwr_pkg::in_beat_t q_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tkwr_pkg::out_beat_t     out_data
);
  import tkwr_pkg::*;
  localparam int WB = $clog2(WINDOW_MINUTES);
  localparam int TB = $clog2(TOP_COUNT + 1);
  localparam int RB = $clog2(2 * TOP_COUNT + 1);
  localparam int SB = (WINDOW_MINUTES > 1) ? $clog2(WINDOW_MINUTES) : 1;
  localparam logic [WB-1:0] WLAST = WB'(WINDOW_MINUTES - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_ADV = 5'b00010, S_SCAN = 5'b00100,
    S_INS  = 5'b01000, S_REP = 5'b10000
  } st_t;

  st_t st_r;
  logic signed [15:0] hv_r [TOP_COUNT];
  logic [5:0]         hm_r [TOP_COUNT];
  logic signed [15:0] lv_r [TOP_COUNT];
  logic [5:0]         lm_r [TOP_COUNT];
  logic [TB-1:0]      fill_r;
  logic signed [15:0] mn_r [WINDOW_MINUTES];
  logic signed [15:0] mx_r [WINDOW_MINUTES];
  logic [WINDOW_MINUTES-1:0] has_r;
  logic [5:0]  cur_r;
  logic [WB-1:0] slot_r;
  logic [SB-1:0] seen_r;
  logic [15:0] best_r;
  logic [5:0]  bstart_r;
  logic [WB-1:0] si_r;
  logic        any_r;
  logic signed [15:0] lo_r, hi_r;
  logic        after_r;  // scan belongs to a minute step (else to the report)
  logic [RB-1:0] ri_r;
  in_beat_t    it_r;
  logic        ov_r;
  out_beat_t   od_r;

  assign q_ready   = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  logic [WB-1:0] slot_inc;
  assign slot_inc = (slot_r == WLAST) ? '0 : slot_r + 1'b1;
  logic full_win;
  assign full_win = (32'(seen_r) >= WINDOW_MINUTES - 1);

  logic signed [16:0] dif;
  assign dif = 17'(hi_r) - 17'(lo_r);

  logic [TB-1:0] ridx;
  always_comb begin
    if (32'(ri_r) < TOP_COUNT) ridx = TB'(ri_r);
    else ridx = TB'(32'(ri_r) - TOP_COUNT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; fill_r <= '0; has_r <= '0; cur_r <= '0; slot_r <= '0;
      seen_r <= '0; best_r <= '0; bstart_r <= '0; ov_r <= 1'b0; ri_r <= '0;
      si_r <= '0; any_r <= 1'b0; after_r <= 1'b0;
    end else begin
      // The report state either holds the output register or reloads it.
      if (ov_r && out_ready && st_r != S_REP) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            it_r <= q_data;
            if (q_data.minute > cur_r) begin
              si_r <= '0; any_r <= 1'b0; after_r <= 1'b1;
              if (!full_win) st_r <= S_ADV;
              else st_r <= S_SCAN;
            end else st_r <= S_INS;
          end
        end
        S_SCAN: begin
          if (has_r[si_r]) begin
            if (!any_r || mn_r[si_r] < lo_r) lo_r <= mn_r[si_r];
            if (!any_r || mx_r[si_r] > hi_r) hi_r <= mx_r[si_r];
            any_r <= 1'b1;
          end
          if (si_r == WLAST) st_r <= S_ADV;
          else si_r <= si_r + 1'b1;
        end
        S_ADV: begin
          // finish the score of the window that just closed, then step on or go to the report
          if (full_win && any_r && dif[15:0] > best_r) begin
            best_r   <= dif[15:0];
            bstart_r <= 6'(7'(cur_r) + 7'd1 - 7'(WINDOW_MINUTES));
          end
          if (after_r) begin
            cur_r  <= cur_r + 6'd1;
            slot_r <= slot_inc;
            has_r[slot_inc] <= 1'b0;
            if (!full_win) seen_r <= seen_r + 1'b1;
            si_r <= '0; any_r <= 1'b0;
            if (cur_r + 6'd1 == it_r.minute) st_r <= S_INS;
            else if (32'(seen_r) + 1 >= WINDOW_MINUTES - 1) st_r <= S_SCAN;
            else st_r <= S_ADV;
          end else begin
            ri_r <= '0;
            st_r <= S_REP;
          end
        end
        S_INS: begin
          if (!has_r[slot_r]) begin
            mn_r[slot_r] <= it_r.temperature; mx_r[slot_r] <= it_r.temperature;
            has_r[slot_r] <= 1'b1;
          end else begin
            if (it_r.temperature < mn_r[slot_r]) mn_r[slot_r] <= it_r.temperature;
            if (it_r.temperature > mx_r[slot_r]) mx_r[slot_r] <= it_r.temperature;
          end
          for (int i = 0; i < TOP_COUNT; i++) begin
            // cell i takes the sample if it beats cell i or is the next empty cell, shifts if it beat i-1
            if (TB'(i) <= fill_r) begin
              if (TB'(i) == fill_r || it_r.temperature > hv_r[i]) begin
                if (i > 0 && hv_r[(i > 0) ? i - 1 : 0] < it_r.temperature) begin
                  hv_r[i] <= hv_r[(i > 0) ? i - 1 : 0];
                  hm_r[i] <= hm_r[(i > 0) ? i - 1 : 0];
                end else begin
                  hv_r[i] <= it_r.temperature; hm_r[i] <= cur_r;
                end
              end
              if (TB'(i) == fill_r || it_r.temperature < lv_r[i]) begin
                if (i > 0 && lv_r[(i > 0) ? i - 1 : 0] > it_r.temperature) begin
                  lv_r[i] <= lv_r[(i > 0) ? i - 1 : 0];
                  lm_r[i] <= lm_r[(i > 0) ? i - 1 : 0];
                end else begin
                  lv_r[i] <= it_r.temperature; lm_r[i] <= cur_r;
                end
              end
            end
          end
          if (32'(fill_r) < TOP_COUNT) fill_r <= fill_r + 1'b1;
          if (it_r.last_of_report) begin
            si_r <= '0; any_r <= 1'b0; after_r <= 1'b0;
            st_r <= S_SCAN;
          end else st_r <= S_IDLE;
        end
        S_REP: begin
          if (!ov_r || out_ready) begin
            ov_r <= 1'b1;
            if (32'(ri_r) < 2 * TOP_COUNT) begin
              od_r.rank <= 3'(ridx);
              od_r.difference <= '0;
              od_r.last_result <= 1'b0;
              od_r.entry_valid <= (ridx < fill_r);
              if (32'(ri_r) < TOP_COUNT) begin
                od_r.kind <= KIND_HIGH;
                od_r.at_minute <= (ridx < fill_r) ? hm_r[ridx] : '0;
                od_r.sample_value <= (ridx < fill_r) ? hv_r[ridx] : '0;
              end else begin
                od_r.kind <= KIND_LOW;
                od_r.at_minute <= (ridx < fill_r) ? lm_r[ridx] : '0;
                od_r.sample_value <= (ridx < fill_r) ? lv_r[ridx] : '0;
              end
            end else begin
              od_r.kind <= KIND_DIFF; od_r.rank <= '0;
              od_r.at_minute <= bstart_r; od_r.sample_value <= '0;
              od_r.difference <= best_r; od_r.entry_valid <= 1'b1;
              od_r.last_result <= 1'b1;
              fill_r <= '0; has_r <= '0; cur_r <= '0; slot_r <= '0;
              seen_r <= '0; best_r <= '0; bstart_r <= '0;
              st_r <= S_IDLE;
            end
            ri_r <= ri_r + 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/core/top_k_and_window_range_tracker_core.sv */
// ----------------------------------------------------------------------------
// top_k_and_window_range_tracker_core: streaming top-k and window range
// Keeps highest and lowest samples and the largest range over WINDOW_MINUTES minutes.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid/in_ready   | in_data (in_beat_t)
// out_    | output    | out_valid/out_ready | out_data (out_beat_t)
//
// An ordinary beat is accepted in the idle state and then inserted.
// Each minute step passes through the step state, after a scan over the
// per-minute ring once a full window exists.
// A last beat adds a scan over the per-minute ring, a scoring step and
// 2*TOP_COUNT+1 report beats.
// Reset is synchronous and active low; a two-beat queue lets input keep
// arriving while the back engine or the output stalls.
`default_nettype none
module top_k_and_window_range_tracker_core #(
  parameter int TOP_COUNT      = tkwr_pkg::TOP_COUNT_DEF,
  parameter int WINDOW_MINUTES = tkwr_pkg::WINDOW_MINUTES_DEF,
  parameter int REPORT_MINUTES = tkwr_pkg::REPORT_MINUTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tkwr_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tkwr_pkg::out_beat_t      out_data
);
  import tkwr_pkg::*;
  logic     q_valid, q_ready;
  in_beat_t q_data;

  // Front clamps minutes and buffers beats.
  tkwr_front #(.REPORT_MINUTES(REPORT_MINUTES)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  // Back holds all tracking state and drives the report beats.
  tkwr_back #(.TOP_COUNT(TOP_COUNT), .WINDOW_MINUTES(WINDOW_MINUTES)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

/* verif/top_k_and_window_range_tracker_core_tb.sv */
// ----------------------------------------------------------------------------
// top_k_and_window_range_tracker_core_tb: self-checking bench for the tracker
// Drives reports of temperature samples, predicts the top/bottom lists and
// the best ten-minute range, and checks every result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none
module top_k_and_window_range_tracker_core_tb;
  import tkwr_pkg::*;

  localparam int NTOP = TOP_COUNT_DEF;
  localparam int NWIN = WINDOW_MINUTES_DEF;
  localparam int NREP = REPORT_MINUTES_DEF;

  int err_count = 0;

  // Prints one line per mismatch and keeps a running count.
  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    err_count++;
  endtask

  // Scoreboard: tracks the tracker state and holds the expected result beats.
  class tracker_scoreboard;
    logic signed [15:0] hi_val[NTOP], lo_val[NTOP];
    logic [5:0]         hi_min[NTOP], lo_min[NTOP];
    int                 fill;
    logic signed [15:0] win_lo[NWIN], win_hi[NWIN];
    bit                 win_has[NWIN];
    int                 cur_min, seen;
    logic [15:0]        best_diff;
    logic [5:0]         best_start;
    out_beat_t          pending[$];

    function void clear();
      for (int i = 0; i < NTOP; i++) begin
        hi_val[i] = 0; lo_val[i] = 0; hi_min[i] = 0; lo_min[i] = 0;
      end
      for (int i = 0; i < NWIN; i++) win_has[i] = 0;
      fill = 0; cur_min = 0; seen = 0; best_diff = 0; best_start = 0;
    endfunction

    function void insert_sorted(bit want_high, logic signed [15:0] v, int m);
      int pos;
      bit beats;
      pos = fill;
      for (int i = 0; i < fill; i++) begin
        beats = want_high ? (v > hi_val[i]) : (v < lo_val[i]);
        if (beats) begin
          pos = i;
          break;
        end
      end
      if (pos >= NTOP) return;
      for (int i = NTOP - 1; i > pos; i--) begin
        if (want_high) begin
          hi_val[i] = hi_val[i-1]; hi_min[i] = hi_min[i-1];
        end else begin
          lo_val[i] = lo_val[i-1]; lo_min[i] = lo_min[i-1];
        end
      end
      if (want_high) begin
        hi_val[pos] = v; hi_min[pos] = m;
      end else begin
        lo_val[pos] = v; lo_min[pos] = m;
      end
    endfunction

    // Scores the window that ends at the current minute, once it is full.
    function void score_window();
      bit any;
      int lo, hi, d;
      any = 0; lo = 0; hi = 0;
      if (seen < NWIN - 1) return;
      for (int i = 0; i < NWIN; i++) begin
        if (!win_has[i]) continue;
        if (!any || win_lo[i] < lo) lo = win_lo[i];
        if (!any || win_hi[i] > hi) hi = win_hi[i];
        any = 1;
      end
      d = any ? hi - lo : 0;
      if (d > best_diff) begin
        best_diff = d;
        best_start = cur_min + 1 - NWIN;
      end
    endfunction

    function void note_input(in_beat_t b);
      logic signed [15:0] v;
      int m, slot;
      out_beat_t r;
      v = b.temperature;
      m = b.minute;
      if (m >= NREP) m = NREP - 1;
      if (m < cur_min) m = cur_min;
      while (cur_min < m) begin
        score_window();
        cur_min++;
        if (seen < NWIN - 1) seen++;
        win_has[cur_min % NWIN] = 0;
      end
      slot = cur_min % NWIN;
      if (!win_has[slot]) begin
        win_lo[slot] = v; win_hi[slot] = v; win_has[slot] = 1;
      end else begin
        if (v < win_lo[slot]) win_lo[slot] = v;
        if (v > win_hi[slot]) win_hi[slot] = v;
      end
      insert_sorted(1, v, m);
      insert_sorted(0, v, m);
      if (fill < NTOP) fill++;
      if (!b.last_of_report) return;
      score_window();
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < NTOP; i++) begin
          r = '0;
          r.kind = (k == 0) ? KIND_HIGH : KIND_LOW;
          r.rank = i;
          if (i < fill) begin
            r.at_minute    = (k == 0) ? hi_min[i] : lo_min[i];
            r.sample_value = (k == 0) ? hi_val[i] : lo_val[i];
            r.entry_valid  = 1;
          end
          pending.insert(pending.size(), r);
        end
      end
      r = '0;
      r.kind = KIND_DIFF;
      r.at_minute = best_start;
      r.difference = best_diff;
      r.entry_valid = 1;
      r.last_result = 1;
      pending.insert(pending.size(), r);
      clear();
    endfunction

    task check_result(out_beat_t got);
      out_beat_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %p", got));
        return;
      end
      e = pending.pop_front();
      if (got.kind != e.kind)
        report_mismatch($sformatf("kind got %0d exp %0d", got.kind, e.kind));
      if (got.rank != e.rank)
        report_mismatch($sformatf("rank got %0d exp %0d", got.rank, e.rank));
      if (got.at_minute != e.at_minute)
        report_mismatch($sformatf("at_minute got %0d exp %0d kind %0d rank %0d",
                                  got.at_minute, e.at_minute, e.kind, e.rank));
      if (got.sample_value != e.sample_value)
        report_mismatch($sformatf("sample_value got %0d exp %0d kind %0d rank %0d",
                                  got.sample_value, e.sample_value, e.kind, e.rank));
      if (got.difference != e.difference)
        report_mismatch($sformatf("difference got %0d exp %0d",
                                  got.difference, e.difference));
      if (got.entry_valid != e.entry_valid)
        report_mismatch($sformatf("entry_valid got %0d exp %0d kind %0d rank %0d",
                                  got.entry_valid, e.entry_valid, e.kind, e.rank));
      if (got.last_result != e.last_result)
        report_mismatch($sformatf("last_result got %0d exp %0d",
                                  got.last_result, e.last_result));
    endtask
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  in_beat_t  in_data = '0;
  logic      out_ready = 0;
  logic      in_ready, out_valid;
  out_beat_t out_data;

  tracker_scoreboard sb = new();
  bit stall_enable = 1;

  top_k_and_window_range_tracker_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sender burst state: burst_left counts the beats left in the current burst.
  int burst_left = 0;

  // Sends one beat; valid stays up across back-to-back beats within a burst.
  task automatic send_sample(input logic signed [15:0] t, input logic [5:0] m,
                             input bit last);
    in_beat_t b;
    int gap;
    b.temperature = t;
    b.minute = m;
    b.last_of_report = last;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(b);
    burst_left--;
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  // Receiver stall pattern: random ready runs alternate with random stall runs while stall_enable is set.
  initial begin
    int run;
    forever begin
      run = $urandom_range(1, 20);
      repeat (run) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
      if (stall_enable) begin
        run = $urandom_range(1, 8);
        repeat (run) begin
          out_ready <= ($urandom_range(0, 3) == 0);
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // One report: samples at nondecreasing minutes with random content.
  // Occasionally a minute goes backward, jumps past the report end, or skips.
  task automatic random_report(input int count, input int step_max);
    int m, stepr;
    logic signed [15:0] t;
    logic [5:0] mm;
    m = 0;
    for (int i = 0; i < count; i++) begin
      stepr = $urandom_range(0, 9);
      if (stepr < 6) m += $urandom_range(0, step_max);
      else if (stepr < 8) m += $urandom_range(0, 1);
      mm = (m > 63) ? 6'd63 : m[5:0];
      if ($urandom_range(0, 15) == 0) mm = 6'($urandom);
      case ($urandom_range(0, 5))
        0: t = 16'($urandom);
        1: t = $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
        2: t = 16'($urandom_range(0, 7));
        default: t = $signed(16'($urandom_range(0, 1200))) - 16'sd600;
      endcase
      send_sample(t, mm, i == count - 1);
    end
  endtask

  initial begin
    int wait_cnt;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a single-sample report leaves most list slots unfilled.
    send_sample(16'sh7FFF, 6'd0, 1);
    // Equal values tie-break on arrival; report shorter than a window.
    send_sample(16'sd32, 6'd1, 0);
    send_sample(16'sd32, 6'd2, 0);
    send_sample(-16'sh8000, 6'd2, 0);
    send_sample(16'sd32, 6'd1, 1);      // minute going backward
    // Skipped minutes and a clamp past the report end, full windows scored.
    send_sample(-16'sh8000, 6'd0, 0);
    send_sample(16'sh7FFF, 6'd5, 0);
    send_sample(16'sd0, 6'd20, 0);
    send_sample(16'sd100, 6'd21, 0);
    send_sample(-16'sd100, 6'd40, 0);
    send_sample(16'sd7, 6'd63, 0);
    send_sample(16'sd8, 6'd60, 1);
    // Flat values in full windows: no window exceeds zero.
    for (int i = 0; i < 12; i++) send_sample(16'sd5, i[5:0], i == 11);

    // Random reports of mixed length and minute spread.
    for (int r = 0; r < 10; r++)
      random_report($urandom_range(1, 16), $urandom_range(1, 6));

    // Run without receiver stalls, then drain.
    stall_enable = 0;
    random_report(8, 3);
    idle_sender();
    wait_cnt = 0;
    while (sb.pending.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (200) @(posedge clk);
    if (err_count == 0 && sb.pending.size() == 0) begin
      $display("** top_k_and_window_range_tracker_core: PASSED **");
    end else begin
      $display("** top_k_and_window_range_tracker_core: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("** top_k_and_window_range_tracker_core: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
